FILE: design/hsl2rgb_pkg.sv
// Shared constants, types and hue segment logic for the HSL to RGB converter.
`timescale 1ns / 1ps

package hsl2rgb_pkg;

  localparam int NUM_STAGES  = 7;

  // Q16 fraction scale
  localparam int ONE_Q16     = 65536;
  localparam int HALF_Q16    = 32768;
  localparam int THIRD_Q16   = 21845;

  // Input scales
  localparam int HUE_TURN    = 46080;  // 360 degrees in Q9.7
  localparam int PCT_FULL    = 25600;  // 100 percent in Q8.8

  // Q9.7 hue to Q16 turn: (hue * 128 + 45) / 90
  // Q8.8 percent to Q16:  (pct * 128 + 25) / 50
  localparam int HUE_ROUND   = 45;
  localparam int HUE_DIV     = 90;
  localparam int PCT_ROUND   = 25;
  localparam int PCT_DIV     = 50;

  // Floor reciprocals; the quotient estimate is low by at most one
  localparam int RECIP_SHIFT = 23;
  localparam int HUE_RECIP   = (1 << RECIP_SHIFT) / HUE_DIV;
  localparam int PCT_RECIP   = (1 << RECIP_SHIFT) / PCT_DIV;

  typedef enum logic [1:0] {
    SEG_RAMP,
    SEG_HIGH,
    SEG_LOW
  } hue_seg_e;

  typedef struct packed {
    hue_seg_e    seg;
    logic [16:0] fac;
  } chan_t;

  // Clamp a signed Q8.8 percent to 0..100 percent.
  function automatic logic [14:0] clamp_pct(input logic signed [15:0] raw);
    logic [14:0] res;
    if (raw < 16'sd0) begin
      res = '0;
    end else if (raw > 16'(PCT_FULL)) begin
      res = 15'(PCT_FULL);
    end else begin
      res = raw[14:0];
    end
    return res;
  endfunction

  // Wrap a channel hue into 0..1 turn and pick the segment and ramp factor.
  function automatic chan_t hue_segment(input logic signed [17:0] t_raw);
    logic signed [17:0] t_w;
    logic [16:0]        t;
    logic [19:0]        t6;
    logic [18:0]        t3;
    chan_t              c;
    t_w = t_raw;
    if (t_w < 18'sd0) begin
      t_w = t_w + 18'(ONE_Q16);
    end else if (t_w > 18'(ONE_Q16)) begin
      t_w = t_w - 18'(ONE_Q16);
    end
    t  = t_w[16:0];
    t6 = {3'b000, t} * 20'd6;
    t3 = {2'b00, t} * 19'd3;
    c.fac = '0;
    if (t6 < 20'(ONE_Q16)) begin
      c.seg = SEG_RAMP;
      c.fac = t6[16:0];
    end else if (t < 17'(HALF_Q16)) begin
      c.seg = SEG_HIGH;
    end else if (t3 < 19'(2 * ONE_Q16)) begin
      c.seg = SEG_RAMP;
      c.fac = 17'(20'(4 * ONE_Q16) - t6);
    end else begin
      c.seg = SEG_LOW;
    end
    return c;
  endfunction

endpackage

FILE: design/hsl_to_rgb_pixel_converter.sv
// HSL to RGB pixel converter: seven-stage pipeline with valid/stall handshakes.
`timescale 1ns / 1ps

// Converts one color per item from hue (Q9.7 degrees, one wrap of 360 taken off),
// saturation and lightness (Q8.8 percent, clamped to 0..100) into 8-bit red,
// green and blue, with the alpha byte carried alongside unchanged. Throughput
// is one item per clock while stall_i does not back the pipeline up; items pass
// through the seven register stages: clamp and scale, reciprocal multiply,
// quotient correction, q from lightness and saturation, hue segment select,
// ramp multiply, byte scaling. Each stage holds its item only while the stage
// after it is full and stalled, so bubbles close up and stall_o rises only
// when every stage holds an item and stall_i is high. There is no state
// beyond the pipeline; reset only empties it.
module hsl_to_rgb_pixel_converter
  import hsl2rgb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [15:0] hue_deg_i,
  input  logic [15:0] saturation_pct_i,
  input  logic [15:0] lightness_pct_i,
  input  logic [7:0]  alpha_in_i,
  // output channel
  output logic        valid_o,
  input  logic        stall_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  alpha_out_o
);

  localparam int LAST = NUM_STAGES - 1;

  // ------------------------------------------------------------------
  // Pipeline control: a stage loads when it is empty or its successor
  // loads in the same cycle.
  // ------------------------------------------------------------------
  logic [NUM_STAGES-1:0] vld_q, vld_d, rdy;

  always_comb begin
    rdy[LAST] = !vld_q[LAST] || !stall_i;
    for (int k = LAST - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    vld_d = vld_q;
    if (rdy[0]) begin
      vld_d[0] = valid_i;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (rdy[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign stall_o = !rdy[0];
  assign valid_o = vld_q[LAST];

  // ------------------------------------------------------------------
  // Stage 1: wrap hue, clamp percents, form rounded numerators.
  // ------------------------------------------------------------------
  logic [15:0] hue_w;
  logic [14:0] sat_c, lit_c;
  logic [22:0] s1_xh_d, s1_xh_q;
  logic [21:0] s1_xs_d, s1_xs_q, s1_xl_d, s1_xl_q;
  logic [7:0]  s1_alpha_q;

  always_comb begin
    hue_w   = (hue_deg_i >= 16'(HUE_TURN)) ? hue_deg_i - 16'(HUE_TURN) : hue_deg_i;
    sat_c   = clamp_pct($signed(saturation_pct_i));
    lit_c   = clamp_pct($signed(lightness_pct_i));
    s1_xh_d = {hue_w, 7'b0} + 23'(HUE_ROUND);
    s1_xs_d = {sat_c, 7'b0} + 22'(PCT_ROUND);
    s1_xl_d = {lit_c, 7'b0} + 22'(PCT_ROUND);
  end

  // ------------------------------------------------------------------
  // Stage 2: quotient estimate by reciprocal multiply.
  // ------------------------------------------------------------------
  logic [39:0] prod_h, prod_s, prod_l;
  logic [22:0] s2_xh_q;
  logic [21:0] s2_xs_q, s2_xl_q;
  logic [16:0] s2_qh_q, s2_qs_q, s2_ql_q;
  logic [7:0]  s2_alpha_q;

  always_comb begin
    prod_h = 40'(s1_xh_q) * 40'(HUE_RECIP);
    prod_s = 40'(s1_xs_q) * 40'(PCT_RECIP);
    prod_l = 40'(s1_xl_q) * 40'(PCT_RECIP);
  end

  // ------------------------------------------------------------------
  // Stage 3: correct the estimate by one where the remainder allows.
  // ------------------------------------------------------------------
  logic [23:0] rem_h, rem_s, rem_l;
  logic [16:0] h_d, s_d, l_d;
  logic [16:0] s3_h_q, s3_s_q, s3_l_q;
  logic [7:0]  s3_alpha_q;

  always_comb begin
    rem_h = 24'(s2_xh_q) - 24'(s2_qh_q) * 24'(HUE_DIV);
    rem_s = 24'(s2_xs_q) - 24'(s2_qs_q) * 24'(PCT_DIV);
    rem_l = 24'(s2_xl_q) - 24'(s2_ql_q) * 24'(PCT_DIV);
    h_d   = (rem_h >= 24'(HUE_DIV)) ? s2_qh_q + 17'd1 : s2_qh_q;
    s_d   = (rem_s >= 24'(PCT_DIV)) ? s2_qs_q + 17'd1 : s2_qs_q;
    l_d   = (rem_l >= 24'(PCT_DIV)) ? s2_ql_q + 17'd1 : s2_ql_q;
  end

  // ------------------------------------------------------------------
  // Stage 4: q from lightness and saturation, one shared multiplier.
  // Zero saturation gives q equal to l, so no separate gray path.
  // ------------------------------------------------------------------
  logic        l_low;
  logic [17:0] mul_b;
  logic [34:0] prod_q;
  logic [18:0] rnd_q;
  logic [18:0] q_full;
  logic [16:0] s4_q_q, s4_h_q, s4_l_q;
  logic [7:0]  s4_alpha_q;

  always_comb begin
    l_low  = s3_l_q < 17'(HALF_Q16);
    mul_b  = l_low ? 18'(ONE_Q16) + {1'b0, s3_s_q} : {1'b0, s3_s_q};
    prod_q = 35'(s3_l_q) * 35'(mul_b);
    rnd_q  = 19'((prod_q + 35'(HALF_Q16)) >> 16);
    q_full = l_low ? rnd_q : 19'(s3_l_q) + 19'(s3_s_q) - rnd_q;
  end

  // ------------------------------------------------------------------
  // Stage 5: p, spread, and hue segment for each channel.
  // ------------------------------------------------------------------
  logic signed [18:0] p_d;
  logic signed [18:0] q_s;
  logic        [16:0] d_d;
  logic signed [17:0] h_s;
  chan_t              ch_d [3];
  logic signed [18:0] s5_p_q;
  logic        [16:0] s5_q_q, s5_d_q;
  chan_t              s5_ch_q [3];
  logic        [7:0]  s5_alpha_q;

  always_comb begin
    q_s      = $signed({2'b00, s4_q_q});
    p_d      = $signed({1'b0, s4_l_q, 1'b0}) - q_s;
    d_d      = (q_s > p_d) ? 17'(q_s - p_d) : '0;
    h_s      = $signed({1'b0, s4_h_q});
    ch_d[0]  = hue_segment(h_s + 18'(THIRD_Q16));
    ch_d[1]  = hue_segment(h_s);
    ch_d[2]  = hue_segment(h_s - 18'(THIRD_Q16));
  end

  // ------------------------------------------------------------------
  // Stage 6: ramp multiply and channel select.
  // ------------------------------------------------------------------
  logic        [33:0] prod_r [3];
  logic        [18:0] ramp   [3];
  logic signed [18:0] v_d    [3];
  logic signed [18:0] s6_v_q [3];
  logic        [7:0]  s6_alpha_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod_r[c] = 34'(s5_d_q) * 34'(s5_ch_q[c].fac);
      ramp[c]   = 19'((35'(prod_r[c]) + 35'(HALF_Q16)) >> 16);
      unique case (s5_ch_q[c].seg)
        SEG_RAMP: v_d[c] = s5_p_q + $signed({2'b00, ramp[c][16:0]});
        SEG_HIGH: v_d[c] = $signed({2'b00, s5_q_q});
        SEG_LOW:  v_d[c] = s5_p_q;
        default:  v_d[c] = s5_p_q;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Stage 7: clamp to 0..1 and scale to a rounded byte.
  // ------------------------------------------------------------------
  logic [16:0] v_c   [3];
  logic [24:0] byt_p [3];
  logic [7:0]  byt_d [3];
  logic [7:0]  s7_byte_q [3];
  logic [7:0]  s7_alpha_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (s6_v_q[c] < 19'sd0) begin
        v_c[c] = '0;
      end else if (s6_v_q[c] > 19'(ONE_Q16)) begin
        v_c[c] = 17'(ONE_Q16);
      end else begin
        v_c[c] = s6_v_q[c][16:0];
      end
      byt_p[c] = {v_c[c], 8'b0} - 25'(v_c[c]) + 25'(HALF_Q16);
      byt_d[c] = byt_p[c][23:16];
    end
  end

  // ------------------------------------------------------------------
  // Payload registers: load on stage ready, hold otherwise.
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s1_xh_q    <= s1_xh_d;
      s1_xs_q    <= s1_xs_d;
      s1_xl_q    <= s1_xl_d;
      s1_alpha_q <= alpha_in_i;
    end
    if (rdy[1]) begin
      s2_xh_q    <= s1_xh_q;
      s2_xs_q    <= s1_xs_q;
      s2_xl_q    <= s1_xl_q;
      s2_qh_q    <= prod_h[RECIP_SHIFT +: 17];
      s2_qs_q    <= prod_s[RECIP_SHIFT +: 17];
      s2_ql_q    <= prod_l[RECIP_SHIFT +: 17];
      s2_alpha_q <= s1_alpha_q;
    end
    if (rdy[2]) begin
      s3_h_q     <= h_d;
      s3_s_q     <= s_d;
      s3_l_q     <= l_d;
      s3_alpha_q <= s2_alpha_q;
    end
    if (rdy[3]) begin
      s4_q_q     <= q_full[16:0];
      s4_h_q     <= s3_h_q;
      s4_l_q     <= s3_l_q;
      s4_alpha_q <= s3_alpha_q;
    end
    if (rdy[4]) begin
      s5_p_q     <= p_d;
      s5_q_q     <= s4_q_q;
      s5_d_q     <= d_d;
      s5_ch_q    <= ch_d;
      s5_alpha_q <= s4_alpha_q;
    end
    if (rdy[5]) begin
      s6_v_q     <= v_d;
      s6_alpha_q <= s5_alpha_q;
    end
    if (rdy[6]) begin
      s7_byte_q  <= byt_d;
      s7_alpha_q <= s6_alpha_q;
    end
  end

  assign red_o       = s7_byte_q[0];
  assign green_o     = s7_byte_q[1];
  assign blue_o      = s7_byte_q[2];
  assign alpha_out_o = s7_alpha_q;

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the HSL to RGB pixel converter.
`timescale 1ns / 1ps

module tb
  import hsl2rgb_pkg::*;
();

  // One converted color as it leaves the block.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  // Directed stimulus row; typed rows carry a hand-read result, the rest use the predictor.
  typedef struct packed {
    logic [15:0] hue;
    logic [15:0] sat;
    logic [15:0] lit;
    logic [7:0]  alpha;
    logic        typed;
    rgba_t       want;
  } color_row_t;

  localparam int NUM_DIRECTED   = 22;
  localparam int ITEMS_PER_PHASE = 332;
  localparam int NUM_PHASES     = 4;
  localparam int HOLD_CYCLES    = 300;
  localparam int MAX_GAP        = 20;

  localparam color_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    // gray levels with zero saturation: black, white, middle gray
    '{16'd0,     16'd0,     16'd0,     8'h00, 1'b1, '{8'd0,   8'd0,   8'd0,   8'h00}},
    '{16'd0,     16'd0,     16'd25600, 8'hFF, 1'b1, '{8'd255, 8'd255, 8'd255, 8'hFF}},
    '{16'd0,     16'd0,     16'd12800, 8'h5A, 1'b1, '{8'd128, 8'd128, 8'd128, 8'h5A}},
    // primaries at full saturation, half lightness
    '{16'd0,     16'd25600, 16'd12800, 8'hA5, 1'b1, '{8'd255, 8'd0,   8'd0,   8'hA5}},
    '{16'd15360, 16'd25600, 16'd12800, 8'h01, 1'b1, '{8'd0,   8'd255, 8'd0,   8'h01}},
    '{16'd30720, 16'd25600, 16'd12800, 8'h80, 1'b1, '{8'd0,   8'd0,   8'd255, 8'h80}},
    // hue of exactly one full turn wraps back to red
    '{16'd46080, 16'd25600, 16'd12800, 8'h7F, 1'b1, '{8'd255, 8'd0,   8'd0,   8'h7F}},
    // largest hue code, and the last code below one turn
    '{16'hFFFF,  16'd25600, 16'd12800, 8'hC3, 1'b0, '0},
    '{16'd46079, 16'd25600, 16'd12800, 8'h3C, 1'b0, '0},
    // negative saturation clamps to zero: gray
    '{16'd5000,  16'h8000,  16'd12800, 8'h11, 1'b1, '{8'd128, 8'd128, 8'd128, 8'h11}},
    '{16'd40000, 16'hFFFF,  16'd12800, 8'h22, 1'b1, '{8'd128, 8'd128, 8'd128, 8'h22}},
    // saturation above 100 percent clamps
    '{16'd0,     16'h7FFF,  16'd12800, 8'h33, 1'b1, '{8'd255, 8'd0,   8'd0,   8'h33}},
    // lightness below zero and above 100 percent
    '{16'd9000,  16'd25600, 16'h8000,  8'h44, 1'b1, '{8'd0,   8'd0,   8'd0,   8'h44}},
    '{16'd9000,  16'd25600, 16'h7FFF,  8'h55, 1'b1, '{8'd255, 8'd255, 8'd255, 8'h55}},
    '{16'd20000, 16'd12800, 16'hFFFF,  8'h66, 1'b1, '{8'd0,   8'd0,   8'd0,   8'h66}},
    // secondaries and both q branches
    '{16'd7680,  16'd25600, 16'd12800, 8'h77, 1'b0, '0},
    '{16'd38400, 16'd25600, 16'd12800, 8'h88, 1'b0, '0},
    '{16'd3000,  16'd12800, 16'd6400,  8'h99, 1'b0, '0},
    '{16'd25000, 16'd12800, 16'd19200, 8'hAA, 1'b0, '0},
    // smallest nonzero saturation
    '{16'd12345, 16'd1,     16'd12800, 8'hBB, 1'b0, '0},
    // every field at its top code
    '{16'hFFFF,  16'h7FFF,  16'h7FFF,  8'hFF, 1'b1, '{8'd255, 8'd255, 8'd255, 8'hFF}},
    // just past full saturation, just below full lightness
    '{16'd23040, 16'd25601, 16'd25599, 8'hCC, 1'b0, '0}
  };

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        valid_i          = 1'b0;
  logic        stall_o;
  logic [15:0] hue_deg_i        = '0;
  logic [15:0] saturation_pct_i = '0;
  logic [15:0] lightness_pct_i  = '0;
  logic [7:0]  alpha_in_i       = '0;
  logic        valid_o;
  logic        stall_i          = 1'b0;
  logic [7:0]  red_o;
  logic [7:0]  green_o;
  logic [7:0]  blue_o;
  logic [7:0]  alpha_out_o;

  // Shadow of the offered row: tells the monitor whether a hand-read result goes with it.
  logic        row_typed = 1'b0;
  rgba_t       row_want  = '0;

  rgba_t pending_colors [$];
  rgba_t oldest_color;
  int    errors        = 0;
  int    colors_taken  = 0;
  int    colors_seen   = 0;
  int    idle_pct      = 0;
  int    rx_stall_pct  = 0;
  int    hold_left     = 0;

  hsl_to_rgb_pixel_converter dut (
    .clk_i,
    .rst_ni,
    .valid_i,
    .stall_o,
    .hue_deg_i,
    .saturation_pct_i,
    .lightness_pct_i,
    .alpha_in_i,
    .valid_o,
    .stall_i,
    .red_o,
    .green_o,
    .blue_o,
    .alpha_out_o
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Append one expected color behind those already waiting.
  function automatic void queue_color(input rgba_t c);
    pending_colors.insert(pending_colors.size(), c);
  endfunction

  // Clamp a Q8.8 percent to 0..100 and scale it to a Q16 fraction, rounding half up.
  function automatic longint pct_to_frac(input logic [15:0] raw);
    longint v;
    v = longint'($signed(raw));
    if (v < 0) v = 0;
    if (v > PCT_FULL) v = PCT_FULL;
    return (v * ONE_Q16 + PCT_FULL / 2) / PCT_FULL;
  endfunction

  // Piecewise hue function for one channel at turn position t.
  function automatic longint ramp_channel(input longint p, input longint q, input longint t);
    longint d;
    d = q - p;
    if (d < 0) d = 0;
    if (t < 0) t += ONE_Q16;
    if (t > ONE_Q16) t -= ONE_Q16;
    if (6 * t < ONE_Q16) begin
      return p + ((d * (6 * t) + HALF_Q16) >>> 16);
    end else if (2 * t < ONE_Q16) begin
      return q;
    end else if (3 * t < 2 * ONE_Q16) begin
      return p + ((d * (4 * longint'(ONE_Q16) - 6 * t) + HALF_Q16) >>> 16);
    end
    return p;
  endfunction

  function automatic logic [7:0] frac_to_byte(input longint v);
    longint b;
    if (v < 0) v = 0;
    if (v > ONE_Q16) v = ONE_Q16;
    b = (v * 255 + HALF_Q16) >>> 16;
    if (b > 255) b = 255;
    return 8'(b);
  endfunction

  // Work out the converted color for one input item.
  function automatic rgba_t predict_rgba(input logic [15:0] hue, input logic [15:0] sat,
                                         input logic [15:0] lit, input logic [7:0] alpha);
    longint hue_q7;
    longint h;
    longint s;
    longint l;
    longint q;
    longint p;
    rgba_t  c;
    hue_q7 = longint'(hue);
    if (hue_q7 >= HUE_TURN) hue_q7 -= HUE_TURN;
    h = (hue_q7 * ONE_Q16 + HUE_TURN / 2) / HUE_TURN;
    s = pct_to_frac(sat);
    l = pct_to_frac(lit);
    c.alpha = alpha;
    if (s == 0) begin
      c.red   = frac_to_byte(l);
      c.green = c.red;
      c.blue  = c.red;
    end else begin
      if (l < HALF_Q16) begin
        q = (l * (ONE_Q16 + s) + HALF_Q16) >>> 16;
      end else begin
        q = l + s - ((l * s + HALF_Q16) >>> 16);
      end
      p = 2 * l - q;
      c.red   = frac_to_byte(ramp_channel(p, q, h + THIRD_Q16));
      c.green = frac_to_byte(ramp_channel(p, q, h));
      c.blue  = frac_to_byte(ramp_channel(p, q, h - THIRD_Q16));
    end
    return c;
  endfunction

  // Pick a percent code: mostly in range, some boundary codes, some raw 16-bit noise.
  function automatic logic [15:0] random_pct();
    logic [15:0] edges [9];
    edges = '{16'd0, 16'(PCT_FULL), 16'(PCT_FULL / 2), 16'hFFFF, 16'h7FFF, 16'h8000,
              16'd1, 16'(PCT_FULL - 1), 16'(PCT_FULL + 1)};
    case ($urandom_range(0, 9))
      0, 1: return 16'($urandom);
      2: return edges[$urandom_range(0, 8)];
      default: return 16'($urandom_range(0, PCT_FULL));
    endcase
  endfunction

  // Offer one item, hold it until taken, then idle for a random gap.
  task automatic offer_color(input logic [15:0] hue, input logic [15:0] sat,
                             input logic [15:0] lit, input logic [7:0] alpha,
                             input logic typed, input rgba_t want);
    int gap;
    hue_deg_i        <= hue;
    saturation_pct_i <= sat;
    lightness_pct_i  <= lit;
    alpha_in_i       <= alpha;
    row_typed        <= typed;
    row_want         <= want;
    valid_i          <= 1'b1;
    do @(posedge clk_i); while (stall_o);
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Receiver: random stall, or a long counted hold-off when the sender asks for one.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        stall_i   <= 1'b1;
        hold_left <= hold_left - 1;
      end else begin
        stall_i <= ($urandom_range(0, 99) < rx_stall_pct);
      end
    end
  end

  // Monitor: queue a prediction for each taken item, check each delivered result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_i && !stall_o) begin
        if (row_typed) begin
          queue_color(row_want);
        end else begin
          queue_color(predict_rgba(hue_deg_i, saturation_pct_i,
                                   lightness_pct_i, alpha_in_i));
        end
        colors_taken++;
      end
      if (valid_o && !stall_i) begin
        if (pending_colors.size() == 0) begin
          $error("result with no color pending: %0d %0d %0d %0d",
                 red_o, green_o, blue_o, alpha_out_o);
          errors++;
        end else begin
          oldest_color = pending_colors.pop_front();
          colors_seen++;
          if (red_o !== oldest_color.red) begin
            $error("red: expected %0d, got %0d", oldest_color.red, red_o);
            errors++;
          end
          if (green_o !== oldest_color.green) begin
            $error("green: expected %0d, got %0d", oldest_color.green, green_o);
            errors++;
          end
          if (blue_o !== oldest_color.blue) begin
            $error("blue: expected %0d, got %0d", oldest_color.blue, blue_o);
            errors++;
          end
          if (alpha_out_o !== oldest_color.alpha) begin
            $error("alpha_out: expected %0d, got %0d", oldest_color.alpha, alpha_out_o);
            errors++;
          end
        end
      end
    end
  end

  // Main sequence: reset, directed rows, then four throttling phases of random colors.
  initial begin
    logic [15:0] hue;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      offer_color(DIRECTED_ROWS[i].hue, DIRECTED_ROWS[i].sat, DIRECTED_ROWS[i].lit,
                  DIRECTED_ROWS[i].alpha, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      // Phases: free flow, sparse sender, heavy receiver stall, light stall on both sides.
      case (phase)
        0: begin idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin idle_pct = 75; rx_stall_pct = 0;  end
        2: begin idle_pct = 0;  rx_stall_pct = 75; end
        default: begin idle_pct = 25; rx_stall_pct = 25; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Hold the output off for a long stretch while items keep coming, so the pipe backs up.
        if (phase == 0 && n == 50) hold_left <= HOLD_CYCLES;
        case ($urandom_range(0, 19))
          0, 1: hue = 16'($urandom);
          2: hue = ($urandom_range(0, 1) != 0) ? 16'(HUE_TURN) : 16'(HUE_TURN - 1);
          default: hue = 16'($urandom_range(0, HUE_TURN - 1));
        endcase
        offer_color(hue, random_pct(), random_pct(), 8'($urandom), 1'b0, '0);
      end
      // Drop valid and drain so the next phase starts from an empty pipe.
      valid_i <= 1'b0;
      @(posedge clk_i);
      wait (pending_colors.size() == 0);
      @(posedge clk_i);
    end

    // Linger before finishing to catch any stray result.
    repeat (3 * NUM_STAGES) @(posedge clk_i);
    $display("tb: %0d colors taken, %0d results checked", colors_taken, colors_seen);
    $display("tb: covered clamps, hue wrap, gray case, four throttling phases, long back-pressure");
    if (errors == 0 && pending_colors.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Watchdog: far above the slowest legal run.
  initial begin
    #2000000;
    $display("tb: timeout with %0d colors pending", pending_colors.size());
    $display("tb: done, errors");
    $finish;
  end

endmodule
